// File: design/point_in_polygon_winding_unit_macros.svh
// Assertion helpers for the winding unit. Every check is sampled on clk and
// is off while arst_n is low.
`ifndef POINT_IN_POLYGON_WINDING_UNIT_MACROS_SVH
`define POINT_IN_POLYGON_WINDING_UNIT_MACROS_SVH

// Same-cycle implication.
`define PIPW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PIPW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/pipw_pkg.sv
package pipw_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
	localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
	localparam int MAX_SEGMENTS = 65536;
	// two halves per segment, signed
	localparam int WIND_WIDTH   = $clog2(MAX_SEGMENTS) + 3;
	localparam int REG_COUNT    = 2;
	localparam int INDEX_WIDTH  = $clog2(REG_COUNT);

	localparam logic [INDEX_WIDTH-1:0] REG_POINT_X = INDEX_WIDTH'(0);
	localparam logic [INDEX_WIDTH-1:0] REG_POINT_Y = INDEX_WIDTH'(1);

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_UP,
		KIND_DOWN,
		KIND_HALF_UP,
		KIND_HALF_DOWN
	} cross_kind_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
		logic                          last_segment;
	} seg_t;

	typedef struct packed {
		logic inside_res;
		logic closed;
	} res_t;

	// shifted segment plus its classification
	typedef struct packed {
		logic signed [DIFF_WIDTH-1:0] ax;
		logic signed [DIFF_WIDTH-1:0] ay;
		logic signed [DIFF_WIDTH-1:0] bx;
		logic signed [DIFF_WIDTH-1:0] by;
		cross_kind_t                  kind;
		logic                         last;
		logic                         closed;
	} shift_t;

	// the two cross-product terms
	typedef struct packed {
		logic signed [PROD_WIDTH-1:0] p_axby;
		logic signed [PROD_WIDTH-1:0] p_aybx;
		cross_kind_t                  kind;
		logic                         last;
		logic                         closed;
	} cross_t;

endpackage

// File: design/pipw_contour_track.sv
module pipw_contour_track (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  pipw_pkg::seg_t seg,
	output logic           closed
);

	logic                                   chain_ok_q;
	logic                                   at_first_q;
	logic signed [pipw_pkg::COORD_WIDTH-1:0] first_x_q;
	logic signed [pipw_pkg::COORD_WIDTH-1:0] first_y_q;
	logic signed [pipw_pkg::COORD_WIDTH-1:0] prev_x_q;
	logic signed [pipw_pkg::COORD_WIDTH-1:0] prev_y_q;
	logic                                   chain_now;
	logic signed [pipw_pkg::COORD_WIDTH-1:0] first_x_now;
	logic signed [pipw_pkg::COORD_WIDTH-1:0] first_y_now;

	// the opening segment defines the start point and cannot break the chain
	always_comb begin
		if (at_first_q) begin
			chain_now   = 1'b1;
			first_x_now = seg.start_x;
			first_y_now = seg.start_y;
		end else begin
			chain_now   = chain_ok_q && (seg.start_x == prev_x_q) && (seg.start_y == prev_y_q);
			first_x_now = first_x_q;
			first_y_now = first_y_q;
		end
	end

	assign closed = chain_now && (seg.end_x == first_x_now) && (seg.end_y == first_y_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_ok_q <= 1'b1;
			at_first_q <= 1'b1;
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
		end else if (take) begin
			first_x_q <= first_x_now;
			first_y_q <= first_y_now;
			prev_x_q  <= seg.end_x;
			prev_y_q  <= seg.end_y;
			if (seg.last_segment) begin
				chain_ok_q <= 1'b1;
				at_first_q <= 1'b1;
			end else begin
				chain_ok_q <= chain_now;
				at_first_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/pipw_shift_classify.sv
module pipw_shift_classify (
	input  logic                                    clk,
	input  logic                                    adv,
	input  pipw_pkg::seg_t                          seg,
	input  logic                                    closed,
	input  logic signed [pipw_pkg::COORD_WIDTH-1:0] point_x,
	input  logic signed [pipw_pkg::COORD_WIDTH-1:0] point_y,
	output pipw_pkg::shift_t                        shift_s2
);

	logic signed [pipw_pkg::DIFF_WIDTH-1:0] ax, ay, bx, by;
	logic                                  ay_neg, ay_zero, ay_pos;
	logic                                  by_neg, by_zero, by_pos;
	logic                                  ax_pos, bx_pos;
	pipw_pkg::cross_kind_t                 kind;

	// move the test point to the origin; one extra bit keeps it exact
	assign ax = pipw_pkg::DIFF_WIDTH'(seg.start_x) - pipw_pkg::DIFF_WIDTH'(point_x);
	assign ay = pipw_pkg::DIFF_WIDTH'(seg.start_y) - pipw_pkg::DIFF_WIDTH'(point_y);
	assign bx = pipw_pkg::DIFF_WIDTH'(seg.end_x) - pipw_pkg::DIFF_WIDTH'(point_x);
	assign by = pipw_pkg::DIFF_WIDTH'(seg.end_y) - pipw_pkg::DIFF_WIDTH'(point_y);

	assign ay_neg  = ay[pipw_pkg::DIFF_WIDTH-1];
	assign ay_zero = (ay == '0);
	assign ay_pos  = !ay_neg && !ay_zero;
	assign by_neg  = by[pipw_pkg::DIFF_WIDTH-1];
	assign by_zero = (by == '0);
	assign by_pos  = !by_neg && !by_zero;
	assign ax_pos  = !ax[pipw_pkg::DIFF_WIDTH-1] && (ax != '0);
	assign bx_pos  = !bx[pipw_pkg::DIFF_WIDTH-1] && (bx != '0);

	always_comb begin
		if (ay_neg && by_pos) begin
			kind = pipw_pkg::KIND_UP;
		end else if (ay_pos && by_neg) begin
			kind = pipw_pkg::KIND_DOWN;
		end else if (ay_zero && ax_pos) begin
			kind = by_pos ? pipw_pkg::KIND_HALF_UP : pipw_pkg::KIND_HALF_DOWN;
		end else if (by_zero && bx_pos) begin
			kind = ay_neg ? pipw_pkg::KIND_HALF_UP : pipw_pkg::KIND_HALF_DOWN;
		end else begin
			kind = pipw_pkg::KIND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			shift_s2.ax     <= ax;
			shift_s2.ay     <= ay;
			shift_s2.bx     <= bx;
			shift_s2.by     <= by;
			shift_s2.kind   <= kind;
			shift_s2.last   <= seg.last_segment;
			shift_s2.closed <= closed;
		end
	end

endmodule

// File: design/pipw_cross_terms.sv
module pipw_cross_terms (
	input  logic             clk,
	input  logic             adv,
	input  pipw_pkg::shift_t shift_s2,
	output pipw_pkg::cross_t cross_s3
);

	logic signed [pipw_pkg::PROD_WIDTH-1:0] p_axby;
	logic signed [pipw_pkg::PROD_WIDTH-1:0] p_aybx;

	assign p_axby = pipw_pkg::PROD_WIDTH'(shift_s2.ax) * pipw_pkg::PROD_WIDTH'(shift_s2.by);
	assign p_aybx = pipw_pkg::PROD_WIDTH'(shift_s2.ay) * pipw_pkg::PROD_WIDTH'(shift_s2.bx);

	always_ff @(posedge clk) begin
		if (adv) begin
			cross_s3.p_axby <= p_axby;
			cross_s3.p_aybx <= p_aybx;
			cross_s3.kind   <= shift_s2.kind;
			cross_s3.last   <= shift_s2.last;
			cross_s3.closed <= shift_s2.closed;
		end
	end

endmodule

// File: design/pipw_wind_acc.sv
module pipw_wind_acc (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  pipw_pkg::cross_t cross_s3,
	output pipw_pkg::res_t   res_q
);

	logic [pipw_pkg::WIND_WIDTH-1:0] wind_q;
	logic [pipw_pkg::WIND_WIDTH-1:0] delta;
	logic [pipw_pkg::WIND_WIDTH-1:0] wind_next;

	// sign of the cross product without forming the difference
	always_comb begin
		case (cross_s3.kind)
			pipw_pkg::KIND_UP:
				delta = (cross_s3.p_axby > cross_s3.p_aybx) ?
					pipw_pkg::WIND_WIDTH'(2) : '0;
			pipw_pkg::KIND_DOWN:
				delta = (cross_s3.p_axby < cross_s3.p_aybx) ?
					-pipw_pkg::WIND_WIDTH'(2) : '0;
			pipw_pkg::KIND_HALF_UP:   delta = pipw_pkg::WIND_WIDTH'(1);
			pipw_pkg::KIND_HALF_DOWN: delta = '1;
			default:                  delta = '0;
		endcase
	end

	assign wind_next = wind_q + delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wind_q <= '0;
		end else if (take) begin
			wind_q <= cross_s3.last ? '0 : wind_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take && cross_s3.last) begin
			res_q.inside_res <= cross_s3.closed && (wind_next != '0);
			res_q.closed     <= cross_s3.closed;
		end
	end

endmodule

// File: design/point_in_polygon_winding_unit.sv
// Channel   Dir  Handshake                Payload
// seg       in   seg_valid / seg_stall    pipw_pkg::seg_t (start, end, last_segment)
// res       out  res_valid / res_stall    pipw_pkg::res_t (inside_res, closed)
// config    in   wr_en (no wait)          reg_index, wr_data
//
// One segment is taken per clock unless a held result stalls the pipe; a result is
// offered once its last segment has passed the input, shift, product and result
// registers in turn. The two 33x33 cross-product multipliers set the cycle time.
// arst_n clears the pipe, the winding count, the contour tracker and the
// test point. A held result stalls the whole pipe, so seg_stall follows
// res_stall while res_valid is high.
module point_in_polygon_winding_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 seg_valid,
	output logic                                 seg_stall,
	input  pipw_pkg::seg_t                       seg,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output pipw_pkg::res_t                       res,
	input  logic                                 wr_en,
	input  logic [pipw_pkg::INDEX_WIDTH-1:0]     reg_index,
	input  logic [pipw_pkg::COORD_WIDTH-1:0]     wr_data
);

	`include "point_in_polygon_winding_unit_macros.svh"

	logic signed [pipw_pkg::COORD_WIDTH-1:0] point_x_q;
	logic signed [pipw_pkg::COORD_WIDTH-1:0] point_y_q;

	logic             adv;
	logic             valid_s1, valid_s2, valid_s3;
	pipw_pkg::seg_t   seg_s1;
	logic             closed_s1;
	pipw_pkg::shift_t shift_s2;
	pipw_pkg::cross_t cross_s3;
	logic             res_valid_q;

	// Advance every stage together whenever the result register is free or
	// its transfer completes this cycle.
	assign adv       = !res_valid_q || !res_stall;
	assign seg_stall = !adv;
	assign res_valid = res_valid_q;

	// test point registers; the user must write them only while the unit is idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
		end else if (wr_en) begin
			case (reg_index)
				pipw_pkg::REG_POINT_X: point_x_q <= wr_data;
				pipw_pkg::REG_POINT_Y: point_y_q <= wr_data;
				default: ;
			endcase
		end
	end

	// stage valid bits; a bubble moves along like an item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= seg_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			res_valid_q <= valid_s3 && cross_s3.last;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1 <= seg;
		end
	end

	// chaining and closure of the contour, in segment order
	pipw_contour_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (adv && valid_s1),
		.seg    (seg_s1),
		.closed (closed_s1)
	);

	// shift to the test point and sort into crossing cases
	pipw_shift_classify u_shift (
		.clk      (clk),
		.adv      (adv),
		.seg      (seg_s1),
		.closed   (closed_s1),
		.point_x  (point_x_q),
		.point_y  (point_y_q),
		.shift_s2 (shift_s2)
	);

	// the two cross-product terms
	pipw_cross_terms u_cross (
		.clk      (clk),
		.adv      (adv),
		.shift_s2 (shift_s2),
		.cross_s3 (cross_s3)
	);

	// compare the terms, accumulate half windings, load the result on last
	pipw_wind_acc u_wind (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (adv && valid_s3),
		.cross_s3 (cross_s3),
		.res_q    (res)
	);

	`PIPW_ASSERT_NEXT(a_res_only_after_last, adv && !(valid_s3 && cross_s3.last), !res_valid, "result without a last segment")
	`PIPW_ASSERT_NOW(a_inside_needs_closed, res_valid, !res.inside_res || res.closed, "inside reported on an open contour")
	`PIPW_ASSERT_NEXT(a_accept_fills_s1, seg_valid && !seg_stall, valid_s1, "transfer lost at input register")

endmodule

// File: dv/point_in_polygon_winding_checker.sv
`timescale 1ns / 100ps

module point_in_polygon_winding_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             seg_valid,
	input  logic                             seg_stall,
	input  pipw_pkg::seg_t                   seg,
	input  logic                             res_valid,
	input  logic                             res_stall,
	input  pipw_pkg::res_t                   res,
	input  logic                             wr_en,
	input  logic [pipw_pkg::INDEX_WIDTH-1:0] reg_index,
	input  logic [pipw_pkg::COORD_WIDTH-1:0] wr_data,
	input  logic                             run_end,
	output int                               pending,
	output int                               fail_count,
	output int                               results_checked,
	output int                               inside_count
);
	import pipw_pkg::*;

	logic signed [COORD_WIDTH-1:0] pt_x, pt_y;
	logic signed [COORD_WIDTH-1:0] first_x, first_y, prev_x, prev_y;
	logic [WIND_WIDTH-1:0]         winding_halves;
	logic                          chain_ok, opening;
	res_t                          pending_verdicts[$];
	int                            failures, checked, insides;

	logic signed [DIFF_WIDTH-1:0]  ax, ay, bx, by;
	logic signed [PROD_WIDTH-1:0]  p_axby, p_aybx;
	cross_kind_t                   kind;
	logic [WIND_WIDTH-1:0]         delta;
	logic                          closed_now;
	res_t                          verdict;

	always @(posedge clk) begin
		if (!arst_n) begin
			pt_x = '0;
			pt_y = '0;
			first_x = '0;
			first_y = '0;
			prev_x = '0;
			prev_y = '0;
			winding_halves = '0;
			chain_ok = 1'b1;
			opening = 1'b1;
			pending_verdicts.delete();
			failures = 0;
			checked = 0;
			insides = 0;
		end else begin
			if (wr_en) begin
				case (reg_index)
					REG_POINT_X: pt_x = wr_data;
					REG_POINT_Y: pt_y = wr_data;
					default: ;
				endcase
			end

			// a result can never come from a segment taken at the same edge
			if (res_valid && !res_stall) begin
				if (pending_verdicts.size() == 0) begin
					failures++;
					$display("%0t: unexpected result inside_res=%0b closed=%0b",
						$time, res.inside_res, res.closed);
				end else begin
					verdict = pending_verdicts.pop_front();
					checked++;
					if (res.inside_res === 1'b1)
						insides++;
					if (res.inside_res !== verdict.inside_res) begin
						failures++;
						$display("%0t: inside_res mismatch: expected %0b, actual %0b",
							$time, verdict.inside_res, res.inside_res);
					end
					if (res.closed !== verdict.closed) begin
						failures++;
						$display("%0t: closed mismatch: expected %0b, actual %0b",
							$time, verdict.closed, res.closed);
					end
				end
			end

			if (seg_valid && !seg_stall) begin
				// shift to the test point; 33 bits hold any difference
				ax = seg.start_x - pt_x;
				ay = seg.start_y - pt_y;
				bx = seg.end_x - pt_x;
				by = seg.end_y - pt_y;
				p_axby = ax * by;
				p_aybx = ay * bx;
				if (ay < 0 && by > 0)
					kind = (p_axby > p_aybx) ? KIND_UP : KIND_NONE;
				else if (ay > 0 && by < 0)
					kind = (p_aybx > p_axby) ? KIND_DOWN : KIND_NONE;
				else if (ay == 0 && ax > 0)
					kind = (by > 0) ? KIND_HALF_UP : KIND_HALF_DOWN;
				else if (by == 0 && bx > 0)
					kind = (ay < 0) ? KIND_HALF_UP : KIND_HALF_DOWN;
				else
					kind = KIND_NONE;

				case (kind)
					KIND_UP:        delta = WIND_WIDTH'(2);
					KIND_DOWN:      delta = -WIND_WIDTH'(2);
					KIND_HALF_UP:   delta = WIND_WIDTH'(1);
					KIND_HALF_DOWN: delta = '1;
					default:        delta = '0;
				endcase
				winding_halves = winding_halves + delta;

				if (opening) begin
					first_x = seg.start_x;
					first_y = seg.start_y;
					opening = 1'b0;
				end else if (seg.start_x != prev_x || seg.start_y != prev_y) begin
					chain_ok = 1'b0;
				end
				prev_x = seg.end_x;
				prev_y = seg.end_y;

				if (seg.last_segment) begin
					closed_now = chain_ok && seg.end_x == first_x && seg.end_y == first_y;
					verdict.closed = closed_now;
					verdict.inside_res = closed_now && winding_halves != '0;
					pending_verdicts.insert(pending_verdicts.size(), verdict);
					winding_halves = '0;
					chain_ok = 1'b1;
					opening = 1'b1;
				end
			end

			if (run_end && pending_verdicts.size() != 0) begin
				$display("%0t: %0d expected results never arrived",
					$time, pending_verdicts.size());
				failures += pending_verdicts.size();
				pending_verdicts.delete();
			end
		end

		pending <= pending_verdicts.size();
		fail_count <= failures;
		results_checked <= checked;
		inside_count <= insides;
	end

endmodule

// File: dv/point_in_polygon_winding_unit_tb.sv
`timescale 1ns / 100ps

module point_in_polygon_winding_unit_tb;
	import pipw_pkg::*;

	// cycles with no transfer on either channel before the run is called hung
	localparam int IDLE_LIMIT = 1000;
	// leave room for segments with no result to drain from the pipe
	localparam int LATENCY_PAD = 8;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int MAX_VERTS = 16;
	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPRINKLE,
		STALL_RUNS
	} stall_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   seg_valid = 1'b0;
	logic                   seg_stall;
	seg_t                   seg = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	res_t                   res;
	logic                   wr_en = 1'b0;
	logic [INDEX_WIDTH-1:0] reg_index = REG_POINT_X;
	logic [COORD_WIDTH-1:0] wr_data = '0;
	logic                   run_end = 1'b0;

	int pending, fail_count, results_checked, inside_count;

	// stimulus side bookkeeping
	stall_mode_t                   stall_mode = STALL_NONE;
	int                            stall_run = 0;
	int                            idle_cycles = 0;
	int                            burst_left = 0;
	bit                            sender_idles = 1'b1;
	int                            segments_sent = 0;
	int                            contours_sent = 0;
	int                            settings_used = 0;
	logic signed [COORD_WIDTH-1:0] cur_px = '0;
	logic signed [COORD_WIDTH-1:0] cur_py = '0;
	logic signed [COORD_WIDTH-1:0] vx[MAX_VERTS];
	logic signed [COORD_WIDTH-1:0] vy[MAX_VERTS];

	point_in_polygon_winding_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data)
	);

	point_in_polygon_winding_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.seg_valid       (seg_valid),
		.seg_stall       (seg_stall),
		.seg             (seg),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res             (res),
		.wr_en           (wr_en),
		.reg_index       (reg_index),
		.wr_data         (wr_data),
		.run_end         (run_end),
		.pending         (pending),
		.fail_count      (fail_count),
		.results_checked (results_checked),
		.inside_count    (inside_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: either never stall, stall on a random quarter of the cycles,
	// or alternate stalled and free runs whose length is drawn anew each time.
	always @(posedge clk) begin
		case (stall_mode)
			STALL_NONE: res_stall <= 1'b0;
			STALL_SPRINKLE: res_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_run == 0) begin
					res_stall <= !res_stall;
					stall_run <= $urandom_range(1, 12);
				end else begin
					stall_run <= stall_run - 1;
				end
			end
		endcase
	end

	// Watchdog: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((seg_valid && !seg_stall) || (res_valid && !res_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, giving up", $time, IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic seg_t segment_of(input logic signed [COORD_WIDTH-1:0] sx, sy, ex, ey,
			input logic last);
		seg_t s;
		s.start_x = sx;
		s.start_y = sy;
		s.end_x = ex;
		s.end_y = ey;
		s.last_segment = last;
		return s;
	endfunction

	// Random coordinate within reach of base; a reach of zero means anywhere.
	function automatic logic signed [COORD_WIDTH-1:0] near(
			input logic signed [COORD_WIDTH-1:0] base, input int reach);
		int off;
		if (reach == 0)
			return $urandom;
		off = int'($urandom_range(0, 2 * reach)) - reach;
		return base + off;
	endfunction

	// Offer one segment and hold it until the transfer. A new burst may open
	// with a gap; otherwise valid stays high straight into the next segment.
	task automatic push_segment(input seg_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = 0;
			if (sender_idles)
				gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3);
			if (gap != 0) begin
				seg_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		seg_valid <= 1'b1;
		seg <= item;
		@(posedge clk);
		while (seg_stall) @(posedge clk);
		burst_left--;
		segments_sent++;
		if (item.last_segment)
			contours_sent++;
	endtask

	// Drop valid, wait until every owed result is in, then let the pipe run dry.
	task automatic settle();
		seg_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	// Both registers, back to back, only while the block is idle.
	task automatic write_point(input logic signed [COORD_WIDTH-1:0] x, y);
		wr_en <= 1'b1;
		reg_index <= REG_POINT_X;
		wr_data <= x;
		@(posedge clk);
		reg_index <= REG_POINT_Y;
		wr_data <= y;
		@(posedge clk);
		wr_en <= 1'b0;
		cur_px = x;
		cur_py = y;
		settings_used++;
	endtask

	initial begin
		int   pick, n, reach, cut, k;
		seg_t s;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, test point at the origin ----
		write_point(0, 0);
		stall_mode <= STALL_RUNS;

		// counterclockwise square: one turn, inside
		push_segment(segment_of(-10, -10, 10, -10, 1'b0));
		push_segment(segment_of(10, -10, 10, 10, 1'b0));
		push_segment(segment_of(10, 10, -10, 10, 1'b0));
		push_segment(segment_of(-10, 10, -10, -10, 1'b1));
		// clockwise square: minus one turn, still inside
		push_segment(segment_of(-10, -10, -10, 10, 1'b0));
		push_segment(segment_of(-10, 10, 10, 10, 1'b0));
		push_segment(segment_of(10, 10, 10, -10, 1'b0));
		push_segment(segment_of(10, -10, -10, -10, 1'b1));
		// triangle with a vertex on the positive x axis: two half steps
		push_segment(segment_of(5, 0, 0, 5, 1'b0));
		push_segment(segment_of(0, 5, -5, -5, 1'b0));
		push_segment(segment_of(-5, -5, 5, 0, 1'b1));
		// degenerate contour straight through the point: zero cross product
		push_segment(segment_of(-5, -5, 5, 5, 1'b0));
		push_segment(segment_of(5, 5, -5, -5, 1'b1));
		// both ends on the positive axis, only the start vertex counts
		push_segment(segment_of(3, 0, 8, 0, 1'b0));
		push_segment(segment_of(8, 0, 3, 0, 1'b1));
		// single-segment contours at the coordinate extremes, closed and open
		push_segment(segment_of(C_MIN, C_MAX, C_MIN, C_MAX, 1'b1));
		push_segment(segment_of(C_MAX, C_MIN, C_MAX, C_MAX, 1'b1));
		// square whose second start misses the first end: never closed
		push_segment(segment_of(-10, -10, 10, -10, 1'b0));
		push_segment(segment_of(11, -10, 10, 10, 1'b0));
		push_segment(segment_of(10, 10, -10, 10, 1'b0));
		push_segment(segment_of(-10, 10, -10, -10, 1'b1));

		// extreme test point: differences span the full 33 bits
		settle();
		write_point(C_MIN, C_MAX);
		push_segment(segment_of(C_MAX, C_MIN, C_MAX, C_MAX, 1'b0));
		push_segment(segment_of(C_MAX, C_MAX, C_MIN, C_MIN, 1'b0));
		push_segment(segment_of(C_MIN, C_MIN, C_MAX, C_MIN, 1'b1));

		// ---- random phases, each with its own test point and idling ----
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: write_point(C_MAX, C_MIN);
				1: write_point(C_MIN, C_MAX);
				2: write_point(0, 0);
				3: write_point($urandom, $urandom);
				4: write_point($urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50);
				default: write_point(C_MIN, C_MIN);
			endcase
			sender_idles = (p != 2);
			case (p)
				0, 4: stall_mode <= STALL_SPRINKLE;
				2: stall_mode <= STALL_NONE;
				default: stall_mode <= STALL_RUNS;
			endcase

			k = segments_sent;
			while (segments_sent - k < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					// noise: unchained random segments, sometimes marked last
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++) begin
						s = {$urandom, $urandom, $urandom, $urandom, 1'b0};
						s.last_segment = (i == n - 1) || ($urandom_range(0, 3) == 0);
						push_segment(s);
					end
				end else begin
					// mostly small polygons around the point; a tight reach puts
					// vertices on the axis and lines through the point often
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_VERTS)
						: $urandom_range(3, 6);
					case ($urandom_range(0, 2))
						0: reach = 4;
						1: reach = 1000;
						default: reach = 0;
					endcase
					for (int i = 0; i < n; i++) begin
						vx[i] = near(cur_px, reach);
						vy[i] = near(cur_py, reach);
					end
					// some contours get a broken link, a few are left open
					cut = (n > 1 && pick < 25) ? $urandom_range(1, n - 1) : 0;
					for (int i = 0; i < n; i++) begin
						s = segment_of(vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n],
							i == n - 1);
						if (cut != 0 && i == cut)
							s.start_x = s.start_x + 1;
						if (i == n - 1 && pick >= 25 && pick < 32)
							s.end_y = s.end_y ^ (32'd1 << $urandom_range(0, 31));
						push_segment(s);
					end
				end
			end
		end

		// ---- wind down and report ----
		settle();
		run_end <= 1'b1;
		@(posedge clk);
		run_end <= 1'b0;
		@(posedge clk);

		$display("Run covered %0d segments in %0d contours under %0d test points;",
			segments_sent, contours_sent, settings_used);
		$display("%0d results compared, %0d of them inside.",
			results_checked, inside_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/pipw_pkg.sv
design/pipw_contour_track.sv
design/pipw_shift_classify.sv
design/pipw_cross_terms.sv
design/pipw_wind_acc.sv
design/point_in_polygon_winding_unit.sv
dv/point_in_polygon_winding_checker.sv
dv/point_in_polygon_winding_unit_tb.sv
